### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key-value cache unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

   // Field widths of the request and response channels
   localparam int KIND_BITS  = 1;
   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 16;

   // Default sizes of the entry array
   localparam int ENTRIES_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT   = 16;
   localparam int VALUE_WIDTH_DEFAULT = 16;

   // Configuration register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CAP_BITS      = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Register indexes
   localparam logic CSR_CAPACITY = 1'b0;

   // Operation codes
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } lkvc_req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] read_value;
   } lkvc_rsp_type;

endpackage

`default_nettype wire

### rtl/lkvc_req_if.sv
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: valid/ready handshake with kind, key and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [lkvc_pkg::KEY_BITS-1:0]   key;
   logic [lkvc_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

`default_nettype wire

### rtl/lkvc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: valid/ready handshake with found and read_value.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [lkvc_pkg::VALUE_BITS-1:0] read_value;

   modport source (output valid, output found, output read_value, input ready);
   modport sink   (input valid, input found, input read_value, output ready);
endinterface

`default_nettype wire

### rtl/lkvc_csr.sv
// ----------------------------------------------------------------------------
// lkvc_csr
// APB-style register port holding the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [lkvc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [lkvc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output      logic [lkvc_pkg::CSR_DATA_BITS-1:0] prdata,
   output      logic                               pready,
   output      logic [lkvc_pkg::CAP_BITS-1:0]      capacity
);

   logic [lkvc_pkg::CAP_BITS-1:0] capacity_ff;
   logic [lkvc_pkg::CAP_BITS-1:0] capacity_in;
   logic                          sel_capacity;

   assign sel_capacity = (paddr[2] == lkvc_pkg::CSR_CAPACITY);
   assign pready       = 1'b1;

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && sel_capacity) begin
         capacity_in = pwdata[lkvc_pkg::CAP_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lkvc_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_capacity) begin
         prdata = lkvc_pkg::CSR_DATA_BITS'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

`default_nettype wire

### rtl/lkvc_core.sv
// ----------------------------------------------------------------------------
// lkvc_core
// Entry array with parallel key match, recency ranks and LRU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_core #(
   parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [lkvc_pkg::CAP_BITS-1:0] capacity,
   input  wire logic                          enable,
   input  wire lkvc_pkg::lkvc_req_type        cmd,
   output      lkvc_pkg::lkvc_rsp_type        result
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);

   logic [ENTRIES-1:0]     valid_ff;
   logic [ENTRIES-1:0]     valid_in;
   logic [KEY_WIDTH-1:0]   key_ff   [ENTRIES];
   logic [KEY_WIDTH-1:0]   key_in   [ENTRIES];
   logic [VALUE_WIDTH-1:0] value_ff [ENTRIES];
   logic [VALUE_WIDTH-1:0] value_in [ENTRIES];
   logic [RANK_W-1:0]      rank_ff  [ENTRIES];
   logic [RANK_W-1:0]      rank_in  [ENTRIES];
   logic [FILL_W-1:0]      fill_ff;
   logic [FILL_W-1:0]      fill_in;

   logic [31:0]            key_wide;
   logic [31:0]            value_wide;
   logic [31:0]            read_wide;
   logic [KEY_WIDTH-1:0]   cmd_key;
   logic [VALUE_WIDTH-1:0] cmd_value;

   logic [ENTRIES-1:0]     hit_vec;
   logic [ENTRIES-1:0]     victim_vec;
   logic [ENTRIES-1:0]     free_vec;
   logic [ENTRIES-1:0]     free_first;
   logic [ENTRIES-1:0]     target_vec;
   logic [VALUE_WIDTH-1:0] hit_value;
   logic [RANK_W-1:0]      hit_rank;
   logic [FILL_W-1:0]      fill_last;
   logic [FILL_W-1:0]      eff_cap;
   logic [FILL_W-1:0]      limit;
   logic                   hit;
   logic                   is_put;
   logic                   evict;
   logic                   insert;
   logic                   update;

   assign key_wide   = 32'(cmd.key);
   assign value_wide = 32'(cmd.value);
   assign cmd_key    = key_wide[KEY_WIDTH-1:0];
   assign cmd_value  = value_wide[VALUE_WIDTH-1:0];
   assign is_put     = (cmd.kind == lkvc_pkg::KIND_PUT);

   // ranks of valid entries always form 0..fill-1, so the LRU entry holds fill-1
   assign fill_last  = fill_ff - FILL_W'(1);
   assign free_vec   = ~valid_ff;
   assign free_first = free_vec & (~free_vec + ENTRIES'(1));

   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (key_ff[i] == cmd_key);
         victim_vec[i] = valid_ff[i] && (FILL_W'(rank_ff[i]) == fill_last);
         if (hit_vec[i]) begin
            hit_value = hit_value | value_ff[i];
            hit_rank  = hit_rank | rank_ff[i];
         end
      end
   end

   always_comb begin
      if (capacity == '0) begin
         eff_cap = FILL_W'(1);
      end else if (32'(capacity) > 32'(ENTRIES)) begin
         eff_cap = FILL_W'(ENTRIES);
      end else begin
         eff_cap = FILL_W'(capacity);
      end
   end

   assign hit    = |hit_vec;
   assign evict  = !hit && is_put && (fill_ff >= eff_cap) && (fill_ff != '0);
   assign insert = !hit && is_put && !evict && (|free_vec);
   assign update = enable && (hit || evict || insert);

   always_comb begin
      if (hit) begin
         target_vec = hit_vec;
         limit      = FILL_W'(hit_rank);
      end else if (evict) begin
         target_vec = victim_vec;
         limit      = fill_last;
      end else if (insert) begin
         target_vec = free_first;
         limit      = fill_ff;
      end else begin
         target_vec = '0;
         limit      = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
         if (update) begin
            if (target_vec[i]) begin
               rank_in[i] = '0;
               if (is_put) begin
                  key_in[i]   = cmd_key;
                  value_in[i] = cmd_value;
               end
               if (insert) begin
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (FILL_W'(rank_ff[i]) < limit)) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
      end
      if (update && insert) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
         rank_ff[i]  <= rank_in[i];
      end
   end

   assign read_wide         = 32'(hit_value);
   assign result.found      = hit;
   assign result.read_value = (hit && !is_put) ? read_wide[lkvc_pkg::VALUE_BITS-1:0] : '0;

endmodule

`default_nettype wire

### rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one get or put request per clock while the response side is not
// stalled and returns exactly one response per request: the request is
// captured in a request register, all entries are compared in parallel
// and ranks, key and value are updated in the same cycle as the compare,
// and the response is held in an output register. Throughput is one
// request per cycle when responses are not stalled, set by the combinational
// match and rank update across all ENTRIES entries. No clearing pass is
// needed after reset; the entries start invalid at once. The capacity
// register (address 0) limits the number of entries used before eviction;
// 0 acts as 1 and values above ENTRIES act as ENTRIES. Write it only while the unit is idle.
`default_nettype none

module lru_key_value_cache_unit #(
   parameter int ENTRIES     = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   lkvc_req_if.sink                                req_port,
   lkvc_rsp_if.source                              rsp_port,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [lkvc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [lkvc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output      logic [lkvc_pkg::CSR_DATA_BITS-1:0] prdata,
   output      logic                               pready
);

   logic [lkvc_pkg::CAP_BITS-1:0] capacity;
   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   lkvc_pkg::lkvc_req_type        stage_ff;
   lkvc_pkg::lkvc_req_type        stage_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   lkvc_pkg::lkvc_rsp_type        out_ff;
   lkvc_pkg::lkvc_rsp_type        out_in;
   lkvc_pkg::lkvc_rsp_type        core_result;
   logic                          advance;
   logic                          take;

   lkvc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   lkvc_core #(
      .ENTRIES     (ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity),
      .enable   (advance),
      .cmd      (stage_ff),
      .result   (core_result)
   );

   assign advance        = stage_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !stage_valid_ff || advance;
   assign take           = req_port.valid && req_port.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_in       = stage_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in   = 1'b1;
         out_in         = core_result;
         stage_valid_in = 1'b0;
      end
      if (take) begin
         stage_valid_in = 1'b1;
         stage_in.kind  = req_port.kind;
         stage_in.key   = req_port.key;
         stage_in.value = req_port.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.found      = out_ff.found;
   assign rsp_port.read_value = out_ff.read_value;

endmodule

`default_nettype wire
